FILE: design/csae_pkg.sv
// ----------------------------------------------------------------------------
// Calendar schedule alarm engine - shared definitions
// Types, constants and opcodes used by the cells and the top.
// ----------------------------------------------------------------------------
package csae_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int RELAYS      = 4;

  localparam int IDX_W    = 4;
  localparam int DATES_W  = 48;
  localparam int ACTION_W = 40;
  localparam int MASK_W   = 4;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_FIRE  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [7:0] NO_BOUND     = 8'hFF;
  localparam logic [7:0] HOUR_LIMIT   = 8'd24;
  localparam logic [7:0] MINUTE_LIMIT = 8'd60;
  localparam logic [7:0] SECOND_LIMIT = 8'd60;
  localparam logic [7:0] YEAR_MAX     = 8'd99;
  localparam logic [7:0] MONTH_MAX    = 8'd12;
  localparam logic [7:0] DAY_MAX      = 8'd31;
  localparam logic [7:0] WEEKDAY_MAX  = 8'd7;

  // mask bits beyond the RELAYS count never switch
  localparam logic [MASK_W-1:0] RELAY_MASK =
    (RELAYS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << RELAYS) - 1);

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    idx;
    logic [DATES_W-1:0]  dates;
    logic [ACTION_W-1:0] action;
  } wr_t;

  typedef struct packed {
    logic       fire;
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] weekday;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] armed_hour;
    logic [7:0] armed_minute;
  } query_t;

  typedef struct packed {
    logic              valid;
    logic [7:0]        best_hour;
    logic [7:0]        best_minute;
    logic [MASK_W-1:0] on;
    logic [MASK_W-1:0] off;
  } tok_t;

endpackage

FILE: design/csae_in_if.sv
// ----------------------------------------------------------------------------
// Calendar schedule alarm engine - request channel
// Valid/ready channel carrying one operation and the current date and time.
// ----------------------------------------------------------------------------
interface csae_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  entry_index;
  logic [47:0] entry_dates;
  logic [39:0] entry_action;
  logic [7:0]  now_year;
  logic [7:0]  now_month;
  logic [7:0]  now_day;
  logic [7:0]  now_weekday;
  logic [7:0]  now_hour;
  logic [7:0]  now_minute;
  logic [7:0]  now_second;

  modport source (
    output valid, opcode, entry_index, entry_dates, entry_action,
    output now_year, now_month, now_day, now_weekday, now_hour, now_minute, now_second,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, entry_dates, entry_action,
    input  now_year, now_month, now_day, now_weekday, now_hour, now_minute, now_second,
    output ready
  );
endinterface

FILE: design/csae_out_if.sv
// ----------------------------------------------------------------------------
// Calendar schedule alarm engine - result channel
// Valid/ready channel carrying the search and relay result of one operation.
// ----------------------------------------------------------------------------
interface csae_out_if;
  logic       valid;
  logic       ready;
  logic       time_valid;
  logic       next_found;
  logic [4:0] next_hour;
  logic [5:0] next_minute;
  logic       rearmed;
  logic [3:0] relay_on_mask;
  logic [3:0] relay_off_mask;

  modport source (
    output valid, time_valid, next_found, next_hour, next_minute, rearmed,
    output relay_on_mask, relay_off_mask,
    input  ready
  );
  modport sink (
    input  valid, time_valid, next_found, next_hour, next_minute, rearmed,
    input  relay_on_mask, relay_off_mask,
    output ready
  );
endinterface

FILE: design/csae_cell.sv
// ----------------------------------------------------------------------------
// Calendar schedule alarm engine - schedule cell
// Holds one schedule entry, folds it into the passing scan token and
// registers the token for the next cell.
// ----------------------------------------------------------------------------
module csae_cell #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  csae_pkg::wr_t     wr,
  input  csae_pkg::query_t  query,
  input  csae_pkg::tok_t    tok_in,
  output csae_pkg::tok_t    tok_out
);

  localparam bit WRITABLE = (INDEX < (1 << csae_pkg::IDX_W));

  logic [csae_pkg::DATES_W-1:0]  windows;
  logic [csae_pkg::ACTION_W-1:0] actions;
  csae_pkg::tok_t                tok_next;

  logic                        date_ok;
  logic                        cand;
  logic                        hit;
  logic [7:0]                  eh;
  logic [7:0]                  em;
  logic [csae_pkg::MASK_W-1:0] v_on;
  logic [csae_pkg::MASK_W-1:0] v_off;

  function automatic logic win_ok(logic [7:0] lo, logic [7:0] hi, logic [7:0] now);
    return ((lo <= now) || (lo == csae_pkg::NO_BOUND)) && (hi >= now);
  endfunction

  assign eh = actions[15:8];
  assign em = actions[23:16];

  assign date_ok = win_ok(windows[7:0],   windows[15:8],  query.year)
                && win_ok(windows[23:16], windows[31:24], query.month)
                && win_ok(windows[39:32], windows[47:40], query.day)
                && actions[query.weekday[2:0]];

  assign cand = date_ok && (eh >= query.hour) && ((eh > query.hour) || (em > query.minute));
  assign hit  = query.fire && date_ok && (eh == query.armed_hour)
             && (em == query.armed_minute) && (actions[31:24] == 8'd0);

  assign v_on  = actions[35:32] & csae_pkg::RELAY_MASK;
  assign v_off = actions[39:36] & ~actions[35:32] & csae_pkg::RELAY_MASK;

  always_comb begin
    tok_next = tok_in;
    if (cand) begin
      if (eh < tok_in.best_hour) begin
        tok_next.best_hour   = eh;
        tok_next.best_minute = em;
      end else if ((eh == tok_in.best_hour) && (em < tok_in.best_minute)) begin
        tok_next.best_minute = em;
      end
    end
    if (hit) begin
      tok_next.on  = (tok_in.on & ~v_off) | v_on;
      tok_next.off = (tok_in.off & ~v_on) | v_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      windows <= '1;
      actions <= '1;
    end else if (WRITABLE && wr.en && (wr.idx == csae_pkg::IDX_W'(INDEX))) begin
      windows <= wr.dates;
      actions <= wr.action;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

FILE: design/calendar_schedule_alarm_engine_unit.sv
// ----------------------------------------------------------------------------
// Calendar schedule alarm engine
// Schedule table with next-alarm search and relay switching on alarm fire.
// ----------------------------------------------------------------------------
// req carries one operation per transfer: write entry, check and re-arm, or
// alarm fired, with the current date and time. rsp returns one result per
// request, in order.
// The table lives in a row of ENTRIES cells. A check or fire sends a scan
// token down the row, one cell per cycle, from the scan state; its result
// is captured as the token leaves the last cell and then registered on rsp
// from the done state. A write, an unused opcode or an invalid time skips
// the scan state and goes from idle to the done state.
// A new request is taken while a previous result still waits on rsp; a
// finished result waits inside the block until the rsp register is free, and
// req stays not ready meanwhile.
// Reset empties every entry (all ones) and disarms the alarm time (255:255).
// ----------------------------------------------------------------------------
module calendar_schedule_alarm_engine_unit #(
  parameter int ENTRIES = csae_pkg::ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  csae_in_if.sink      req,
  csae_out_if.source   rsp
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic       time_valid;
    logic       next_found;
    logic [4:0] next_hour;
    logic [5:0] next_minute;
    logic       rearmed;
    logic [3:0] relay_on_mask;
    logic [3:0] relay_off_mask;
  } res_t;

  state_t state;
  state_t state_next;

  csae_pkg::wr_t    wr;
  csae_pkg::query_t q;
  csae_pkg::query_t query_bus;
  csae_pkg::tok_t   head;
  csae_pkg::tok_t   link [ENTRIES+1];

  logic [7:0] armed_hour;
  logic [7:0] armed_minute;
  res_t       res;
  res_t       out_res;
  logic       rsp_valid;

  logic accept;
  logic time_ok;
  logic scan_op;
  logic start;
  logic load;
  logic found;
  logic rearm;
  csae_pkg::tok_t last;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  assign time_ok = (req.now_hour < csae_pkg::HOUR_LIMIT)
                && (req.now_minute < csae_pkg::MINUTE_LIMIT)
                && (req.now_second < csae_pkg::SECOND_LIMIT)
                && (req.now_year <= csae_pkg::YEAR_MAX)
                && (req.now_month <= csae_pkg::MONTH_MAX)
                && (req.now_day <= csae_pkg::DAY_MAX)
                && (req.now_weekday <= csae_pkg::WEEKDAY_MAX);

  assign scan_op = (req.opcode == csae_pkg::OP_CHECK) || (req.opcode == csae_pkg::OP_FIRE);
  assign start   = accept && scan_op && time_ok;

  assign wr.en     = accept && (req.opcode == csae_pkg::OP_WRITE);
  assign wr.idx    = req.entry_index;
  assign wr.dates  = req.entry_dates;
  assign wr.action = req.entry_action;

  always_comb begin
    query_bus = q;
    query_bus.armed_hour   = armed_hour;
    query_bus.armed_minute = armed_minute;
  end

  assign link[0] = head;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    csae_cell #(
      .INDEX (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (wr),
      .query   (query_bus),
      .tok_in  (link[k]),
      .tok_out (link[k+1])
    );
  end

  assign last = link[ENTRIES];

  assign found = !((last.best_hour == q.hour) && (last.best_minute < q.minute))
              && (last.best_hour < csae_pkg::HOUR_LIMIT)
              && (last.best_hour >= q.hour)
              && (last.best_minute < csae_pkg::MINUTE_LIMIT);
  assign rearm = found && ((armed_hour != last.best_hour) || (armed_minute != last.best_minute));

  assign load = (state == ST_DONE) && (!rsp_valid || rsp.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = start ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (last.valid) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      head.valid   <= 1'b0;
      armed_hour   <= 8'hFF;
      armed_minute <= 8'hFF;
    end else begin
      state            <= state_next;
      head.valid       <= start;
      head.best_hour   <= 8'hFF;
      head.best_minute <= 8'hFF;
      head.on          <= '0;
      head.off         <= '0;
      if ((state == ST_SCAN) && last.valid && rearm) begin
        armed_hour   <= last.best_hour;
        armed_minute <= last.best_minute;
      end
    end
  end

  // query and pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      q.fire    <= (req.opcode == csae_pkg::OP_FIRE);
      q.year    <= req.now_year;
      q.month   <= req.now_month;
      q.day     <= req.now_day;
      q.weekday <= req.now_weekday;
      q.hour    <= req.now_hour;
      q.minute  <= req.now_minute;
      q.armed_hour   <= 8'hFF;
      q.armed_minute <= 8'hFF;
      res <= '0;
    end else if ((state == ST_SCAN) && last.valid) begin
      res.time_valid     <= 1'b1;
      res.next_found     <= found;
      res.next_hour      <= found ? last.best_hour[4:0] : 5'd0;
      res.next_minute    <= found ? last.best_minute[5:0] : 6'd0;
      res.rearmed        <= rearm;
      res.relay_on_mask  <= last.on;
      res.relay_off_mask <= last.off;
    end
  end

  // rsp output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res <= res;
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.time_valid     = out_res.time_valid;
  assign rsp.next_found     = out_res.next_found;
  assign rsp.next_hour      = out_res.next_hour;
  assign rsp.next_minute    = out_res.next_minute;
  assign rsp.rearmed        = out_res.rearmed;
  assign rsp.relay_on_mask  = out_res.relay_on_mask;
  assign rsp.relay_off_mask = out_res.relay_off_mask;

endmodule
